// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Plain SystemVerilog, no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define NCW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define NCW_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/ncwrc_pkg.sv =====
// Shared constants and codes for the nearest-center search block.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package ncwrc_pkg;

  // Table sizes and coordinate format.
  localparam int MAX_CENTERS = 64;
  localparam int MAX_DIMS    = 16;
  localparam int COORD_BITS  = 16;

  // Field widths of the words on the ports.
  localparam int SLOT_W    = $clog2(MAX_CENTERS);
  localparam int DIM_W     = $clog2(MAX_DIMS);
  localparam int CENTERS_W = 7;
  localparam int DIMS_W    = 5;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int DIST_W    = 36;
  localparam int SUM_W     = 48;

  // Square of a coordinate difference and center table geometry.
  localparam int SQ_W      = 2 * COORD_BITS;
  localparam int TAB_DEPTH = MAX_CENTERS * MAX_DIMS;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTERS = 1'b0,
    REG_DIMS    = 1'b1
  } cfg_reg_t;

  // Operation carried by an input word.
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_POINT = 1'b1
  } op_t;

endpackage

// ===== rtl/nearest_center_with_running_cost.sv =====
// Nearest-center search with a saturating running cost.
// Depends on ncwrc_pkg; the checker in ncwrc_checker.sv binds to it.
`timescale 1ns / 1ps

// A center load word and a point word that is not the last coordinate of its
// point are stored and leave the block idle. The last coordinate of a point
// starts a walk over the center table, one center coordinate per cycle through
// a single subtract, square and accumulate pipeline fed by the center memory
// and point buffer read ports; no word is taken until the walk has drained
// and its result has moved to the output register. The result sits there; the
// block keeps taking load and point words while it waits to be read, and only
// the end of the next walk waits for it. Configuration writes take effect at
// once and are meant for an idle block.
module nearest_center_with_running_cost (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration write port
  input  logic                                 cfg_we,
  input  logic [ncwrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ncwrc_pkg::CFG_W-1:0]          cfg_wdata,
  // Input words
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_op,
  input  logic [ncwrc_pkg::SLOT_W-1:0]         in_center_slot,
  input  logic [ncwrc_pkg::DIM_W-1:0]          in_coord_index,
  input  logic signed [ncwrc_pkg::COORD_BITS-1:0] in_coord_value,
  input  logic                                 in_first_point,
  // Result words
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ncwrc_pkg::SLOT_W-1:0]         out_nearest_label,
  output logic [ncwrc_pkg::DIST_W-1:0]         out_nearest_distance,
  output logic [ncwrc_pkg::SUM_W-1:0]          out_running_sum,
  output logic                                 out_sum_saturated
);
  import ncwrc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Position of one table read as it moves down the pipeline.
  typedef struct packed {
    logic              first;
    logic              last;
    logic              fin;
    logic [SLOT_W-1:0] slot;
  } tag_t;

  state_t state_r, state_nxt;

  logic [CENTERS_W-1:0] centers_r;
  logic [DIMS_W-1:0]    dims_r;
  logic [CENTERS_W-1:0] centers_clamp;
  logic [DIMS_W-1:0]    dims_raw;
  logic [DIMS_W-1:0]    dims_clamp;
  logic [SLOT_W-1:0]    slot_last;
  logic [DIM_W-1:0]     dim_last;

  logic accept, load_acc, pt_acc, pt_last;

  logic signed [COORD_BITS-1:0] ctab_mem [TAB_DEPTH];
  logic signed [COORD_BITS-1:0] pbuf_mem [MAX_DIMS];
  logic signed [COORD_BITS-1:0] ctab_q, pbuf_q;

  logic [SLOT_W-1:0] slot_cnt_r;
  logic [DIM_W-1:0]  dim_cnt_r;
  logic              walk_end;

  logic                     s1_v_r, s2_v_r;
  tag_t                     s1_tag_r, s2_tag_r;
  logic signed [COORD_BITS:0]     diff;
  logic signed [2*COORD_BITS+1:0] prod;
  logic [SQ_W-1:0]          sq_r;

  logic [DIST_W:0]   acc_sum;
  logic [DIST_W-1:0] acc_val;
  logic [DIST_W-1:0] acc_r;
  logic [DIST_W-1:0] best_dist_r;
  logic [SLOT_W-1:0] best_label_r;

  logic [SUM_W-1:0] cost_r, cost_base, cost_nxt;
  logic [SUM_W:0]   cost_sum;
  logic             sat_r, sat_nxt, restart_r;

  logic                out_valid_r;
  logic [SLOT_W-1:0]   out_label_r;
  logic [DIST_W-1:0]   out_dist_r;
  logic [SUM_W-1:0]    out_sum_r;
  logic                out_sat_r;
  logic                out_free, finish_fire;

  // Zero acts as one, counts over the table size are clipped; dims uses bits 4:0.
  assign dims_raw = cfg_wdata[DIMS_W-1:0];

  always_comb begin
    if (cfg_wdata == '0) begin
      centers_clamp = CENTERS_W'(1);
    end else if (cfg_wdata > CFG_W'(MAX_CENTERS)) begin
      centers_clamp = CENTERS_W'(MAX_CENTERS);
    end else begin
      centers_clamp = CENTERS_W'(cfg_wdata);
    end
    if (dims_raw == '0) begin
      dims_clamp = DIMS_W'(1);
    end else if (dims_raw > DIMS_W'(MAX_DIMS)) begin
      dims_clamp = DIMS_W'(MAX_DIMS);
    end else begin
      dims_clamp = dims_raw;
    end
  end

  // Configuration registers hold the clamped counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centers_r <= CENTERS_W'(1);
      dims_r    <= DIMS_W'(2);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTERS: centers_r <= centers_clamp;
        REG_DIMS:    dims_r    <= dims_clamp;
        default:     ;
      endcase
    end
  end

  assign slot_last = SLOT_W'(centers_r - CENTERS_W'(1));
  assign dim_last  = DIM_W'(dims_r - DIMS_W'(1));

  // Input handshake: words are taken only while the sequencer is idle.
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_acc = accept && (in_op == OP_LOAD);
  assign pt_acc   = accept && (in_op == OP_POINT);
  assign pt_last  = pt_acc && (in_coord_index == dim_last);

  // Center table: written by load words, read one coordinate per walk cycle.
  // The address is slot * MAX_DIMS + coordinate, a plain concatenation.
  always_ff @(posedge clk) begin
    if (load_acc) begin
      ctab_mem[{in_center_slot, in_coord_index}] <= in_coord_value;
    end
    ctab_q <= ctab_mem[{slot_cnt_r, dim_cnt_r}];
  end

  // Point buffer: written by point words, read alongside the center table.
  always_ff @(posedge clk) begin
    if (pt_acc) begin
      pbuf_mem[in_coord_index] <= in_coord_value;
    end
    pbuf_q <= pbuf_mem[dim_cnt_r];
  end

  // Walk counters: coordinate inner, center outer.
  assign walk_end = (dim_cnt_r == dim_last) && (slot_cnt_r == slot_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_cnt_r <= '0;
      dim_cnt_r  <= '0;
    end else if (pt_last) begin
      slot_cnt_r <= '0;
      dim_cnt_r  <= '0;
    end else if (state_r == S_WALK) begin
      if (dim_cnt_r == dim_last) begin
        dim_cnt_r  <= '0;
        slot_cnt_r <= slot_cnt_r + SLOT_W'(1);
      end else begin
        dim_cnt_r <= dim_cnt_r + DIM_W'(1);
      end
    end
  end

  // Stage valid bits follow the memory read and the squaring register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= (state_r == S_WALK);
      s2_v_r <= s1_v_r;
    end
  end

  // Difference and square of one coordinate pair.
  assign diff = $signed({pbuf_q[COORD_BITS-1], pbuf_q})
              - $signed({ctab_q[COORD_BITS-1], ctab_q});
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    s1_tag_r.first <= (dim_cnt_r == '0);
    s1_tag_r.last  <= (dim_cnt_r == dim_last);
    s1_tag_r.fin   <= walk_end;
    s1_tag_r.slot  <= slot_cnt_r;
    s2_tag_r       <= s1_tag_r;
    sq_r           <= prod[SQ_W-1:0];
  end

  // Saturating accumulation of the squares of one center.
  assign acc_sum = (s2_tag_r.first ? '0 : {1'b0, acc_r}) + (DIST_W + 1)'(sq_r);
  assign acc_val = acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];

  // Keep the best center; a later one wins only with a strictly smaller distance.
  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      acc_r <= acc_val;
      if (s2_tag_r.last && ((s2_tag_r.slot == '0) || (acc_val < best_dist_r))) begin
        best_dist_r  <= acc_val;
        best_label_r <= s2_tag_r.slot;
      end
    end
  end

  // Running cost: cleared by a pending restart, then added with saturation.
  assign cost_base = restart_r ? '0 : cost_r;
  assign cost_sum  = {1'b0, cost_base} + (SUM_W + 1)'(best_dist_r);
  assign cost_nxt  = cost_sum[SUM_W] ? SUM_MAX : cost_sum[SUM_W-1:0];
  assign sat_nxt   = (sat_r && !restart_r) || cost_sum[SUM_W];

  assign out_free    = !out_valid_r || out_ready;
  assign finish_fire = (state_r == S_FINISH) && out_free;

  // Next state of the walk sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (pt_last) state_nxt = S_WALK;
      S_WALK:   if (walk_end) state_nxt = S_DRAIN;
      S_DRAIN:  if (s2_v_r && s2_tag_r.fin) state_nxt = S_FINISH;
      S_FINISH: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer state, running cost and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cost_r      <= '0;
      sat_r       <= 1'b0;
      restart_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish_fire) begin
        out_valid_r <= 1'b1;
        out_label_r <= best_label_r;
        out_dist_r  <= best_dist_r;
        out_sum_r   <= cost_nxt;
        out_sat_r   <= sat_nxt;
        cost_r      <= cost_nxt;
        sat_r       <= sat_nxt;
        restart_r   <= 1'b0;
      end else begin
        if (out_ready) begin
          out_valid_r <= 1'b0;
        end
        if (pt_acc && in_first_point) begin
          restart_r <= 1'b1;
        end
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_nearest_label    = out_label_r;
  assign out_nearest_distance = out_dist_r;
  assign out_running_sum      = out_sum_r;
  assign out_sum_saturated    = out_sat_r;

endmodule

// ===== rtl/ncwrc_checker.sv =====
// Port-level checks for the nearest-center search block, bound to its top level.
// Depends on ncwrc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ncwrc_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 cfg_we,
  input logic [ncwrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [ncwrc_pkg::CFG_W-1:0]          cfg_wdata,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 in_op,
  input logic [ncwrc_pkg::SLOT_W-1:0]         in_center_slot,
  input logic [ncwrc_pkg::DIM_W-1:0]          in_coord_index,
  input logic signed [ncwrc_pkg::COORD_BITS-1:0] in_coord_value,
  input logic                                 in_first_point,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [ncwrc_pkg::SLOT_W-1:0]         out_nearest_label,
  input logic [ncwrc_pkg::DIST_W-1:0]         out_nearest_distance,
  input logic [ncwrc_pkg::SUM_W-1:0]          out_running_sum,
  input logic                                 out_sum_saturated
);
  import ncwrc_pkg::*;

  // A stalled result word holds its label, distance and running sum.
  `NCW_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_nearest_label) && $stable(out_nearest_distance) && $stable(out_running_sum), "result word changed while stalled")

  // A center load never produces a result on the next cycle.
  `NCW_ASSERT(a_load_no_result, clk, rst_n, in_valid && in_ready && (in_op == OP_LOAD) |=> !$rose(out_valid), "center load produced a result")

  // The saturation flag is only shown with the sum pinned at its maximum.
  `NCW_ASSERT(a_sat_at_max, clk, rst_n, out_valid && out_sum_saturated |-> out_running_sum == SUM_MAX, "saturation flag without a full sum")

  // The running sum always includes the distance reported with it.
  `NCW_NEVER(a_sum_covers_dist, clk, rst_n, out_valid && (out_running_sum < SUM_W'(out_nearest_distance)), "running sum below nearest distance")

endmodule

bind nearest_center_with_running_cost ncwrc_checker u_ncwrc_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the nearest-center search block with running cost.
// Depends on ncwrc_pkg and nearest_center_with_running_cost; result words are checked
// first against a directed table, then against a behavioral predictor on random point streams.
`timescale 1ns / 1ps

module testbench;
  import ncwrc_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 5;
  // Idle cycles added after the last expected result, before the registers are written.
  localparam int DRAIN_CYCLES = 8;
  // Longest walk over the center table plus output margin.
  localparam int END_CYCLES   = MAX_CENTERS * MAX_DIMS + 8;
  localparam int RANDOM_WORDS = 850;
  localparam int CYCLE_LIMIT  = 20_000_000;
  localparam int DIR_ROWS     = 24;
  // Far points sent in a row to build up a large running sum.
  localparam int FAR_POINTS   = 40;

  // One input word and one result word.
  typedef struct packed {
    op_t                          op;
    logic [SLOT_W-1:0]            slot;
    logic [DIM_W-1:0]             idx;
    logic signed [COORD_BITS-1:0] value;
    logic                         first;
  } coord_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0] label;
    logic [DIST_W-1:0] distance;
    logic [SUM_W-1:0]  sum;
    logic              sat;
  } center_match_t;

  // Directed stimulus rows: a word, or a register write between words.
  typedef enum logic {
    ROW_WORD = 1'b0,
    ROW_REG  = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    coord_word_t      w;
    cfg_reg_t         reg_sel;
    logic [CFG_W-1:0] reg_val;
    logic             typed;
    center_match_t    result;
  } stim_row_t;

  // Block ports; the inputs are known from time zero.
  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_W-1:0]             cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_op = 1'b0;
  logic [SLOT_W-1:0]            in_center_slot = '0;
  logic [DIM_W-1:0]             in_coord_index = '0;
  logic signed [COORD_BITS-1:0] in_coord_value = '0;
  logic                         in_first_point = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [SLOT_W-1:0]            out_nearest_label;
  logic [DIST_W-1:0]            out_nearest_distance;
  logic [SUM_W-1:0]             out_running_sum;
  logic                         out_sum_saturated;

  nearest_center_with_running_cost i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_center_slot      (in_center_slot),
    .in_coord_index      (in_coord_index),
    .in_coord_value      (in_coord_value),
    .in_first_point      (in_first_point),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_nearest_label   (out_nearest_label),
    .out_nearest_distance(out_nearest_distance),
    .out_running_sum     (out_running_sum),
    .out_sum_saturated   (out_sum_saturated)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state and its copy of the registers.
  logic signed [COORD_BITS-1:0] center_coords [MAX_CENTERS][MAX_DIMS];
  logic signed [COORD_BITS-1:0] point_coords [MAX_DIMS];
  logic [SUM_W-1:0]             cost_total;
  logic                         restart_pending;
  logic                         saturated_mark;
  logic [CENTERS_W-1:0]         reg_centers;
  logic [DIMS_W-1:0]            reg_dims;

  // Which table and buffer entries have been written, so no unwritten one is read.
  bit center_loaded [MAX_CENTERS][MAX_DIMS];
  bit point_loaded [MAX_DIMS];

  center_match_t expected_matches [$];
  int            mismatch_count = 0;
  int            words_accepted = 0;
  int            cycle_count = 0;
  int            burst_left = 0;
  bit            fast_sender = 1'b0;
  int            ready_mode = 0;
  int            ready_mode_left = 0;
  stim_row_t     directed_rows [DIR_ROWS];

  // Appends one expected result word at the tail of the queue.
  function automatic void queue_match(input center_match_t m);
    expected_matches.insert(expected_matches.size(), m);
  endfunction

  function automatic void reset_model();
    int c;
    int d;
    for (c = 0; c < MAX_CENTERS; c++) begin
      for (d = 0; d < MAX_DIMS; d++) begin
        center_coords[c][d] = '0;
        center_loaded[c][d] = 1'b0;
      end
    end
    for (d = 0; d < MAX_DIMS; d++) begin
      point_coords[d] = '0;
      point_loaded[d] = 1'b0;
    end
    cost_total      = '0;
    restart_pending = 1'b0;
    saturated_mark  = 1'b0;
    reg_centers     = CENTERS_W'(1);
    reg_dims        = DIMS_W'(2);
  endfunction

  // A zero count acts as one; counts above the table size are clipped.
  function automatic int used_centers();
    if (reg_centers == 0) return 1;
    return (int'(reg_centers) > MAX_CENTERS) ? MAX_CENTERS : int'(reg_centers);
  endfunction

  function automatic int used_dims();
    if (reg_dims == 0) return 1;
    return (int'(reg_dims) > MAX_DIMS) ? MAX_DIMS : int'(reg_dims);
  endfunction

  // Squared distance from the buffered point to one center, saturating.
  function automatic longint unsigned center_distance(input int slot, input int dims);
    longint          diff;
    longint unsigned mag;
    longint unsigned sq;
    longint unsigned acc;
    int              d;
    acc = 0;
    for (d = 0; d < dims; d++) begin
      diff = longint'(point_coords[d]) - longint'(center_coords[slot][d]);
      mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
      sq   = mag * mag;
      if (sq > DIST_MAX || acc > DIST_MAX - sq) acc = DIST_MAX;
      else acc = acc + sq;
    end
    return acc;
  endfunction

  // Applies one accepted word to the predictor; returns 1 when it yields a result.
  function automatic bit nearest_center_predict(input coord_word_t w,
                                                output center_match_t r);
    int              dims;
    int              ncent;
    int              best;
    int              c;
    longint unsigned best_dist;
    longint unsigned cand_dist;
    r     = '0;
    dims  = used_dims();
    ncent = used_centers();
    if (w.op == OP_LOAD) begin
      center_coords[w.slot][w.idx] = w.value;
      return 1'b0;
    end
    point_coords[w.idx] = w.value;
    if (w.first) restart_pending = 1'b1;
    if (int'(w.idx) != dims - 1) return 1'b0;

    // Lowest index wins on a tie, so only a strictly smaller distance replaces.
    best      = 0;
    best_dist = center_distance(0, dims);
    for (c = 1; c < ncent; c++) begin
      cand_dist = center_distance(c, dims);
      if (cand_dist < best_dist) begin
        best_dist = cand_dist;
        best      = c;
      end
    end

    if (restart_pending) begin
      cost_total      = '0;
      saturated_mark  = 1'b0;
      restart_pending = 1'b0;
    end
    if (64'(cost_total) > 64'(SUM_MAX) - best_dist) begin
      cost_total     = SUM_MAX;
      saturated_mark = 1'b1;
    end else begin
      cost_total = SUM_W'(64'(cost_total) + best_dist);
    end

    r.label    = SLOT_W'(best);
    r.distance = DIST_W'(best_dist);
    r.sum      = cost_total;
    r.sat      = saturated_mark;
    return 1'b1;
  endfunction

  function automatic bit point_buffer_full(input int dims);
    int d;
    for (d = 0; d < dims; d++) begin
      if (!point_loaded[d]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Coordinates lean toward extremes and a narrow band so that ties occur.
  function automatic logic signed [COORD_BITS-1:0] random_coord();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return COORD_BITS'(-32768);
    if (roll < 8) return COORD_BITS'(32767);
    if (roll < 11) return COORD_BITS'(0);
    if (roll < 14) return COORD_BITS'(-1);
    if (roll < 40) return COORD_BITS'($urandom_range(0, 6) - 3);
    return COORD_BITS'($urandom);
  endfunction

  function automatic coord_word_t make_load(input int slot, input int idx, input int value);
    coord_word_t w;
    w.op    = OP_LOAD;
    w.slot  = SLOT_W'(slot);
    w.idx   = DIM_W'(idx);
    w.value = COORD_BITS'(value);
    w.first = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic coord_word_t make_point(input int idx, input int value, input bit first);
    coord_word_t w;
    w.op    = OP_POINT;
    w.slot  = SLOT_W'($urandom_range(0, MAX_CENTERS - 1));
    w.idx   = DIM_W'(idx);
    w.value = COORD_BITS'(value);
    w.first = first;
    return w;
  endfunction

  // Builders for the directed table.
  function automatic stim_row_t row_load(input int slot, input int idx, input int value);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_WORD;
    row.w    = make_load(slot, idx, value);
    return row;
  endfunction

  function automatic stim_row_t row_point(input int idx, input int value, input bit first);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_WORD;
    row.w    = make_point(idx, value, first);
    return row;
  endfunction

  function automatic stim_row_t row_check(input int idx, input int value, input bit first,
                                          input int label, input longint distance,
                                          input longint sum, input bit sat);
    stim_row_t row;
    row                 = row_point(idx, value, first);
    row.typed           = 1'b1;
    row.result.label    = SLOT_W'(label);
    row.result.distance = DIST_W'(distance);
    row.result.sum      = SUM_W'(sum);
    row.result.sat      = sat;
    return row;
  endfunction

  function automatic stim_row_t row_reg(input cfg_reg_t sel, input int value);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_REG;
    row.reg_sel = sel;
    row.reg_val = CFG_W'(value);
    return row;
  endfunction

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Holds the sender until every expected result has come, plus extra cycles.
  task automatic drain_results(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Register writes happen only on an idle block.
  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (sel == REG_CENTERS) reg_centers = value[CENTERS_W-1:0];
    else reg_dims = value[DIMS_W-1:0];
  endtask

  // Sends one word in bursts with random gaps and records what it should produce.
  task automatic send_word(input coord_word_t w, input bit typed = 1'b0,
                           input center_match_t typed_result = '0);
    center_match_t predicted;
    bit            has_result;
    int            gap;
    if (burst_left == 0) begin
      if (!fast_sender && $urandom_range(0, 149) == 0) drain_results(0);
      if (fast_sender) gap = ($urandom_range(0, 99) == 0) ? $urandom_range(1, 4) : 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(5, 24);
      else gap = $urandom_range(0, 3);
      idle_cycles(gap);
      burst_left = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
    end
    burst_left--;

    @(negedge clk);
    in_valid       <= 1'b1;
    in_op          <= w.op;
    in_center_slot <= w.slot;
    in_coord_index <= w.idx;
    in_coord_value <= w.value;
    in_first_point <= w.first;
    do @(posedge clk); while (!in_ready);

    has_result = nearest_center_predict(w, predicted);
    if (typed) queue_match(typed_result);
    else if (has_result) queue_match(predicted);
    if (w.op == OP_LOAD) center_loaded[w.slot][w.idx] = 1'b1;
    else point_loaded[w.idx] = 1'b1;
    words_accepted++;
  endtask

  // One setting of the registers, loads for unwritten reachable centers, then a mix of points, stray loads and noise.
  task automatic run_phase(input logic [CFG_W-1:0] centers_raw,
                           input logic [CFG_W-1:0] dims_raw);
    coord_word_t w;
    int          ncent;
    int          dims;
    int          npoints;
    int          roll;
    int          trunc;
    int          restart_at;
    int          p;
    int          c;
    int          d;
    drain_results(DRAIN_CYCLES);
    write_reg(REG_CENTERS, centers_raw);
    write_reg(REG_DIMS, dims_raw);
    ncent = used_centers();
    dims  = used_dims();

    // Every center that the search can reach must be loaded first.
    for (c = 0; c < ncent; c++) begin
      for (d = 0; d < dims; d++) begin
        if (!center_loaded[c][d]) send_word(make_load(c, d, random_coord()));
      end
    end

    npoints = (ncent * dims > 128) ? $urandom_range(3, 6) : $urandom_range(8, 30);
    for (p = 0; p < npoints; p++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        // Noise word; a last coordinate over an unfilled buffer becomes a load.
        w.op    = op_t'($urandom_range(0, 1));
        w.slot  = SLOT_W'($urandom_range(0, MAX_CENTERS - 1));
        w.idx   = DIM_W'($urandom_range(0, MAX_DIMS - 1));
        w.value = random_coord();
        w.first = 1'($urandom_range(0, 1));
        if (w.op == OP_POINT && int'(w.idx) == dims - 1 && !point_buffer_full(dims)) begin
          w.op = OP_LOAD;
        end
        send_word(w);
      end else if (roll < 14) begin
        send_word(make_load($urandom_range(0, MAX_CENTERS - 1),
                            $urandom_range(0, MAX_DIMS - 1), random_coord()));
      end else begin
        // Well-formed point, sometimes cut short so a new one starts over it.
        trunc      = (roll < 22) ? $urandom_range(0, dims - 1) : dims;
        restart_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, dims - 1) : -1;
        for (d = 0; d < trunc; d++) begin
          if ($urandom_range(0, 19) == 0) begin
            send_word(make_load($urandom_range(0, MAX_CENTERS - 1),
                                $urandom_range(0, MAX_DIMS - 1), random_coord()));
          end
          if (dims < MAX_DIMS && d == dims - 1 && $urandom_range(0, 5) == 0) begin
            send_word(make_point($urandom_range(dims, MAX_DIMS - 1), random_coord(),
                                 1'($urandom_range(0, 1))));
          end
          send_word(make_point(d, random_coord(), d == restart_at));
        end
      end
    end
  endtask

  // Receiver ready follows one of four modes, each held for a randomly drawn length.
  always @(negedge clk) begin
    if (ready_mode_left == 0) begin
      ready_mode      = $urandom_range(0, 3);
      ready_mode_left = $urandom_range(50, 400);
    end
    ready_mode_left = ready_mode_left - 1;
    case (ready_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ready <= ((cycle_count % 7) > 2);
      end
    endcase
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    center_match_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_matches.size() == 0) begin
        $error("unexpected result word: nearest_label %0d, nearest_distance %0d",
               out_nearest_label, out_nearest_distance);
        mismatch_count++;
      end else begin
        want = expected_matches.pop_front();
        if (out_nearest_label !== want.label) begin
          $error("nearest_label: expected %0d, actual %0d", want.label, out_nearest_label);
          mismatch_count++;
        end
        if (out_nearest_distance !== want.distance) begin
          $error("nearest_distance: expected %0d, actual %0d", want.distance,
                 out_nearest_distance);
          mismatch_count++;
        end
        if (out_running_sum !== want.sum) begin
          $error("running_sum: expected %0d, actual %0d", want.sum, out_running_sum);
          mismatch_count++;
        end
        if (out_sum_saturated !== want.sat) begin
          $error("sum_saturated: expected %0d, actual %0d", want.sat, out_sum_saturated);
          mismatch_count++;
        end
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("nearest_center_with_running_cost: mismatch");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random phases, far points, verdict.
  initial begin
    int i;
    int phase;
    int base_words;
    int c_raw;
    int d_raw;
    reset_model();

    // Registers keep their reset values for the first rows.
    directed_rows = '{
      row_load(0, 0, 0),
      row_load(0, 1, 0),
      row_point(0, 32767, 1'b0),
      row_check(1, -32768, 1'b0, 0, 64'd2147418113, 64'd2147418113, 1'b0),
      row_point(0, 0, 1'b1),
      row_check(1, 0, 1'b0, 0, 64'd0, 64'd0, 1'b0),
      row_point(2, 5, 1'b0),
      row_check(1, 1, 1'b0, 0, 64'd1, 64'd1, 1'b0),
      row_point(0, 3, 1'b1),
      row_check(1, 4, 1'b0, 0, 64'd25, 64'd25, 1'b0),
      row_load(0, 0, 32767),
      row_load(0, 1, -32768),
      row_point(0, -32768, 1'b0),
      row_check(1, 32767, 1'b0, 0, 64'd8589672450, 64'd8589672475, 1'b0),
      row_reg(REG_CENTERS, 3),
      row_reg(REG_DIMS, 1),
      row_load(1, 0, 10),
      row_load(2, 0, 10),
      row_check(0, 10, 1'b1, 1, 64'd0, 64'd0, 1'b0),
      row_check(0, 9, 1'b0, 1, 64'd1, 64'd1, 1'b0),
      row_reg(REG_CENTERS, 0),
      row_check(0, 32767, 1'b0, 0, 64'd0, 64'd1, 1'b0),
      row_reg(REG_DIMS, 0),
      row_check(0, 32766, 1'b0, 0, 64'd1, 64'd2, 1'b0)
    };

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_REG) begin
        drain_results(DRAIN_CYCLES);
        write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
      end else begin
        send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].result);
      end
    end

    // The first phases pin the extremes of both registers.
    base_words = words_accepted;
    for (phase = 0; words_accepted - base_words < RANDOM_WORDS; phase++) begin
      case (phase)
        0: begin
          c_raw = 100;
          d_raw = 1;
        end
        1: begin
          c_raw = 1;
          d_raw = 16;
        end
        2: begin
          c_raw = 0;
          d_raw = 0;
        end
        3: begin
          c_raw = 3;
          d_raw = 127;
        end
        4: begin
          c_raw = 127;
          d_raw = 2;
        end
        default: begin
          case ($urandom_range(0, 9))
            0: c_raw = 0;
            1: c_raw = $urandom_range(65, 127);
            2: c_raw = $urandom_range(13, 64);
            default: c_raw = $urandom_range(1, 12);
          endcase
          case ($urandom_range(0, 9))
            0: d_raw = 0;
            1: d_raw = $urandom_range(17, 31);
            2: d_raw = $urandom_range(7, 16);
            default: d_raw = $urandom_range(1, 6);
          endcase
          // Keep the table fill short when both counts are large.
          if (c_raw > 16 && (d_raw == 0 || d_raw > 4)) d_raw = $urandom_range(1, 4);
          // Upper data bits are dropped by the narrower register.
          if ($urandom_range(0, 3) == 0) d_raw = d_raw | ($urandom_range(1, 3) << DIMS_W);
        end
      endcase
      run_phase(CFG_W'(c_raw), CFG_W'(d_raw));
    end

    // Run the sum up with far points back to back, then restart it.
    drain_results(DRAIN_CYCLES);
    write_reg(REG_CENTERS, CFG_W'(1));
    write_reg(REG_DIMS, CFG_W'(1));
    fast_sender = 1'b1;
    send_word(make_load(0, 0, -32768));
    send_word(make_point(0, 32767, 1'b1));
    repeat (FAR_POINTS) send_word(make_point(0, $urandom_range(32740, 32767), 1'b0));
    send_word(make_point(0, $urandom_range(0, 32767), 1'b1));
    send_word(make_point(0, random_coord(), 1'b0));
    fast_sender = 1'b0;

    drain_results(END_CYCLES);
    if (mismatch_count == 0) begin
      $display("nearest_center_with_running_cost: match");
    end else begin
      $display("nearest_center_with_running_cost: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ncwrc_pkg.sv
rtl/nearest_center_with_running_cost.sv
rtl/ncwrc_checker.sv
tb/sv/testbench.sv
